/* hdl/hrtm_pkg.sv */
// Shared types, constants and helpers for the Hamming ratio-test matcher.
package hrtm_pkg;

	localparam int DESC_WORDS    = 4;
	localparam int WORD_BITS     = 64;
	localparam int DESC_BITS     = DESC_WORDS * WORD_BITS;
	localparam int DESC_BYTE_CNT = DESC_BITS / 8;
	localparam int DIST_W        = 9;
	localparam int RATIO_W       = 3;
	localparam int REG_IDX_W     = 2;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [RATIO_W-1:0] ratio_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACCEPT_LIMIT     = 2'd0,
		REG_INITIAL_DISTANCE = 2'd1,
		REG_RATIO_QUARTERS   = 2'd2
	} reg_idx_t;

	localparam logic REQ_QUERY     = 1'b0;
	localparam logic REQ_CANDIDATE = 1'b1;

	localparam dist_t  ACCEPT_LIMIT_RST = 9'd50;
	localparam dist_t  INIT_DIST_RST    = 9'd100;
	localparam ratio_t RATIO_RST        = 3'd3;

	typedef struct packed {
		dist_t  accept_limit;
		dist_t  initial_distance;
		ratio_t ratio_quarters;
	} cfg_t;

	// one classified transaction between front and back
	typedef struct packed {
		logic  is_cand;
		logic  last;
		dist_t hdist;
	} op_ctl_t;

	function automatic logic [3:0] byte_ones(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, b[i]};
		end
		return n;
	endfunction

endpackage

/* hdl/hrtm_front.sv */
// Front end: accepts transactions, holds the query and scores candidates.
module hrtm_front #(
	parameter int INDEX_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word0,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word1,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word2,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word3,
	input  logic [INDEX_BITS-1:0]                feature_index,
	input  logic                                 last_item,
	output logic                                 q_push,
	input  logic                                 q_full,
	output hrtm_pkg::op_ctl_t                    q_ctl,
	output logic [INDEX_BITS-1:0]                q_idx
);
	import hrtm_pkg::*;

	logic [DESC_BITS-1:0]  query_desc_q;
	logic [DESC_BITS-1:0]  in_desc;
	logic [DESC_BITS-1:0]  xor_w;
	logic [3:0]            byte_cnt_s1 [DESC_BYTE_CNT];
	logic                  vld_s1;
	logic                  cand_s1;
	logic                  last_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  take;
	logic                  adv;
	logic [4:0]            sum16 [16];
	logic [5:0]            sum8 [8];
	logic [6:0]            sum4 [4];
	logic [7:0]            sum2 [2];
	dist_t                 total;

	assign in_desc = {desc_word3, desc_word2, desc_word1, desc_word0};
	assign xor_w   = in_desc ^ query_desc_q;
	assign full    = vld_s1 && q_full;
	assign take    = push && !full;
	assign adv     = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			query_desc_q <= '0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (take && req_type == REQ_QUERY) begin
				query_desc_q <= in_desc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_s1 <= req_type;
			last_s1 <= last_item;
			idx_s1  <= feature_index;
			for (int i = 0; i < DESC_BYTE_CNT; i++) begin
				byte_cnt_s1[i] <= byte_ones(xor_w[8*i +: 8]);
			end
		end
	end

	// adder tree over the byte counts
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sum16[i] = {1'b0, byte_cnt_s1[2*i]} + {1'b0, byte_cnt_s1[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			sum8[i] = {1'b0, sum16[2*i]} + {1'b0, sum16[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			sum4[i] = {1'b0, sum8[2*i]} + {1'b0, sum8[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			sum2[i] = {1'b0, sum4[2*i]} + {1'b0, sum4[2*i+1]};
		end
		total = {1'b0, sum2[0]} + {1'b0, sum2[1]};
	end

	assign q_push        = adv;
	assign q_ctl.is_cand = (cand_s1 == REQ_CANDIDATE);
	assign q_ctl.last    = last_s1;
	assign q_ctl.hdist   = total;
	assign q_idx         = idx_s1;

endmodule

/* hdl/hrtm_queue.sv */
// Short first-in first-out queue between front and back.
module hrtm_queue #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hdl/hrtm_back.sv */
// Back end: best/second-best tracker, verdict and result register.
module hrtm_back #(
	parameter int INDEX_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hrtm_pkg::cfg_t               cfg,
	input  logic                         op_vld,
	output logic                         op_take,
	input  hrtm_pkg::op_ctl_t            op_ctl,
	input  logic [INDEX_BITS-1:0]        op_idx,
	output logic                         empty,
	input  logic                         pop,
	output logic [INDEX_BITS-1:0]        query_id,
	output logic [INDEX_BITS-1:0]        match_id,
	output logic [hrtm_pkg::DIST_W-1:0]  best_distance,
	output logic                         accepted
);
	import hrtm_pkg::*;

	dist_t                 best_q;
	dist_t                 second_q;
	logic [INDEX_BITS-1:0] bidx_q;
	logic                  found_q;
	logic [INDEX_BITS-1:0] qnum_q;
	logic                  out_vld_q;

	dist_t                 nb;
	dist_t                 ns;
	logic [INDEX_BITS-1:0] nidx;
	logic                  nf;
	logic [INDEX_BITS-1:0] nq;
	logic [11:0]           four_best;
	logic [11:0]           ratio_second;
	logic                  acc;
	logic                  out_room;

	assign out_room = !out_vld_q || pop;
	assign op_take  = op_vld && (!op_ctl.last || out_room);
	assign empty    = !out_vld_q;

	always_comb begin
		nb   = best_q;
		ns   = second_q;
		nidx = bidx_q;
		nf   = found_q;
		nq   = qnum_q;
		if (op_ctl.is_cand) begin
			if (op_ctl.hdist < best_q) begin
				nb   = op_ctl.hdist;
				ns   = best_q;
				nidx = op_idx;
				nf   = 1'b1;
			end else if (op_ctl.hdist < second_q) begin
				ns = op_ctl.hdist;
			end
		end else begin
			nq   = op_idx;
			nb   = cfg.initial_distance;
			ns   = cfg.initial_distance;
			nidx = '0;
			nf   = 1'b0;
		end
		four_best    = {1'b0, nb, 2'b00};
		ratio_second = {9'd0, cfg.ratio_quarters} * {3'd0, ns};
		acc          = nf && (nb < cfg.accept_limit) && (four_best < ratio_second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= INIT_DIST_RST;
			second_q  <= INIT_DIST_RST;
			bidx_q    <= '0;
			found_q   <= 1'b0;
			qnum_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (op_take) begin
				qnum_q <= nq;
				if (op_ctl.last) begin
					best_q   <= cfg.initial_distance;
					second_q <= cfg.initial_distance;
					bidx_q   <= '0;
					found_q  <= 1'b0;
				end else begin
					best_q   <= nb;
					second_q <= ns;
					bidx_q   <= nidx;
					found_q  <= nf;
				end
			end
			if (op_take && op_ctl.last) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_take && op_ctl.last) begin
			query_id      <= nq;
			match_id      <= nf ? nidx : '0;
			best_distance <= nb;
			accepted      <= acc;
		end
	end

endmodule

/* hdl/hamming_ratio_test_matcher.sv */
// Top level of the Hamming ratio-test matcher: registers, front, queue, back.
//
// channel   direction  handshake             payload
// input     in         push / full           req_type, desc_word0..3, feature_index, last_item
// result    out        empty / pop           query_id, match_id, best_distance, accepted
// config    in         wr_en                 wr_index, wr_data
//
// One transaction per cycle sustained while full stays low. A closing transaction's
// verdict passes the front stage (XOR and byte counts on the taking edge), the adder
// tree into the queue, then the tracker update into the result register.
// Asynchronous reset clears the query to zero and loads the register defaults.
// A waiting result stalls only closing transactions in the back end; the queue
// fills and full rises once it and the front stage are occupied.
module hamming_ratio_test_matcher #(
	parameter int INDEX_BITS  = 12,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word0,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word1,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word2,
	input  logic [hrtm_pkg::WORD_BITS-1:0]       desc_word3,
	input  logic [INDEX_BITS-1:0]                feature_index,
	input  logic                                 last_item,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [INDEX_BITS-1:0]                query_id,
	output logic [INDEX_BITS-1:0]                match_id,
	output logic [hrtm_pkg::DIST_W-1:0]          best_distance,
	output logic                                 accepted,
	input  logic                                 wr_en,
	input  logic [hrtm_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [hrtm_pkg::DIST_W-1:0]          wr_data
);
	import hrtm_pkg::*;

	localparam int Q_W = $bits(op_ctl_t) + INDEX_BITS;

	cfg_t                  cfg_q;
	logic                  q_push;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_take;
	op_ctl_t               f_ctl;
	logic [INDEX_BITS-1:0] f_idx;
	logic [Q_W-1:0]        q_rd_data;
	op_ctl_t               b_ctl;
	logic [INDEX_BITS-1:0] b_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_limit     <= ACCEPT_LIMIT_RST;
			cfg_q.initial_distance <= INIT_DIST_RST;
			cfg_q.ratio_quarters   <= RATIO_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ACCEPT_LIMIT:     cfg_q.accept_limit     <= wr_data;
				REG_INITIAL_DISTANCE: cfg_q.initial_distance <= wr_data;
				REG_RATIO_QUARTERS:   cfg_q.ratio_quarters   <= wr_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	hrtm_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.desc_word0   (desc_word0),
		.desc_word1   (desc_word1),
		.desc_word2   (desc_word2),
		.desc_word3   (desc_word3),
		.feature_index(feature_index),
		.last_item    (last_item),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_ctl        (f_ctl),
		.q_idx        (f_idx)
	);

	hrtm_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data({f_ctl, f_idx}),
		.full   (q_full),
		.rd_en  (q_take),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	assign b_ctl = op_ctl_t'(q_rd_data[Q_W-1:INDEX_BITS]);
	assign b_idx = q_rd_data[INDEX_BITS-1:0];

	hrtm_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.op_vld       (!q_empty),
		.op_take      (q_take),
		.op_ctl       (b_ctl),
		.op_idx       (b_idx),
		.empty        (empty),
		.pop          (pop),
		.query_id     (query_id),
		.match_id     (match_id),
		.best_distance(best_distance),
		.accepted     (accepted)
	);

	a_full_only_when_queue_full: assert property (
		@(posedge clk) disable iff (!arst_n) full |-> q_full
	) else $error("full raised while the queue has room");

	a_accept_below_limit: assert property (
		@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> (best_distance < cfg_q.accept_limit)
	) else $error("accepted verdict with best distance at or above the limit");

	a_no_result_overwrite: assert property (
		@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |-> !(q_take && b_ctl.last)
	) else $error("closing transaction taken while a result is still waiting");

endmodule
